@@ rtl/kms_pkg.sv @@
`timescale 1ns / 1ps
// kms_pkg: shared constants, types and the key map of the keypad matrix scanner.
// No dependencies; used by kms_scan_core and keypad_matrix_scanner.
package kms_pkg;

   localparam int KP_ROWS = 4;
   localparam int KP_COLS = 3;
   localparam int KP_KEYS = KP_ROWS * KP_COLS;

   localparam int HISTORY_BITS_DEFAULT = 32;

   localparam int ELAPSED_WIDTH = 16;
   localparam int INDEX_WIDTH   = 4;
   localparam int CHAR_WIDTH    = 7;

   localparam logic [ELAPSED_WIDTH-1:0] LOCKOUT_RESET = 16'd200;
   localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX   = 16'hFFFF;

   // request command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SCAN = 1'b1;

   // ASCII codes: the base of the digit run, and the keys that do not follow it
   localparam logic [CHAR_WIDTH-1:0] CHAR_ONE  = 7'h31;
   localparam logic [CHAR_WIDTH-1:0] CHAR_STAR = 7'h2A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_HASH = 7'h23;

   localparam logic [INDEX_WIDTH-1:0] IDX_STAR = 4'd9;
   localparam logic [INDEX_WIDTH-1:0] IDX_ZERO = 4'd10;
   localparam logic [INDEX_WIDTH-1:0] IDX_HASH = 4'd11;

   typedef struct packed {
      logic                   hit;
      logic [INDEX_WIDTH-1:0] index;
   } scan_result_type;

   // key index to ASCII: 0..8 -> '1'..'9', then '*', '0', '#'
   function automatic logic [CHAR_WIDTH-1:0] key_char(input logic [INDEX_WIDTH-1:0] idx);
      logic [CHAR_WIDTH-1:0] ch;
      case (idx)
         IDX_STAR: ch = CHAR_STAR;
         IDX_ZERO: ch = CHAR_ZERO;
         IDX_HASH: ch = CHAR_HASH;
         default:  ch = CHAR_ONE + {3'd0, idx};
      endcase
      return ch;
   endfunction

endpackage

@@ rtl/kms_scan_core.sv @@
`timescale 1ns / 1ps
// kms_scan_core: next-state logic for one request (tick or scan).
// Depends on kms_pkg.
module kms_scan_core #(
   parameter int HISTORY_BITS = kms_pkg::HISTORY_BITS_DEFAULT
) (
   input  logic                                cmd,
   input  logic [kms_pkg::KP_KEYS-1:0]         key_levels,
   input  logic [HISTORY_BITS-1:0]             hist      [kms_pkg::KP_KEYS],
   input  logic [kms_pkg::ELAPSED_WIDTH-1:0]   elapsed_ms,
   input  logic [kms_pkg::ELAPSED_WIDTH-1:0]   lockout_ms,
   output logic [HISTORY_BITS-1:0]             hist_next [kms_pkg::KP_KEYS],
   output logic [kms_pkg::ELAPSED_WIDTH-1:0]   elapsed_next,
   output kms_pkg::scan_result_type            result
);

   logic [HISTORY_BITS:0]   shifted [kms_pkg::KP_KEYS];
   logic [HISTORY_BITS-1:0] hist_sh [kms_pkg::KP_KEYS];
   logic [kms_pkg::KP_KEYS-1:0] nz;
   logic                    armed;
   logic                    found;
   logic [1:0]              hit_row;
   logic [kms_pkg::INDEX_WIDTH-1:0] hit_idx;

   // shift level into each history; top bit drops
   always_comb begin
      for (int k = 0; k < kms_pkg::KP_KEYS; k++) begin
         shifted[k] = {hist[k], key_levels[k]};
         hist_sh[k] = shifted[k][HISTORY_BITS-1:0];
         nz[k]      = |hist_sh[k];
      end
   end

   assign armed = (cmd == kms_pkg::CMD_SCAN) && (elapsed_ms > lockout_ms);

   // row-major priority pick
   always_comb begin
      found   = 1'b0;
      hit_row = '0;
      hit_idx = '0;
      for (int r = 0; r < kms_pkg::KP_ROWS; r++) begin
         for (int c = 0; c < kms_pkg::KP_COLS; c++) begin
            if (!found && nz[r*kms_pkg::KP_COLS + c]) begin
               found   = 1'b1;
               hit_row = 2'(r);
               hit_idx = kms_pkg::INDEX_WIDTH'(r*kms_pkg::KP_COLS + c);
            end
         end
      end
   end

   assign result.hit   = armed && found;
   assign result.index = hit_idx;

   // after a hit, rows below the hit row hold only this scan's level
   always_comb begin
      for (int r = 0; r < kms_pkg::KP_ROWS; r++) begin
         for (int c = 0; c < kms_pkg::KP_COLS; c++) begin
            if (cmd != kms_pkg::CMD_SCAN) begin
               hist_next[r*kms_pkg::KP_COLS + c] = hist[r*kms_pkg::KP_COLS + c];
            end else if (!result.hit) begin
               hist_next[r*kms_pkg::KP_COLS + c] = hist_sh[r*kms_pkg::KP_COLS + c];
            end else if (2'(r) > hit_row) begin
               hist_next[r*kms_pkg::KP_COLS + c] =
                  {{(HISTORY_BITS-1){1'b0}}, key_levels[r*kms_pkg::KP_COLS + c]};
            end else begin
               hist_next[r*kms_pkg::KP_COLS + c] = '0;
            end
         end
      end
   end

   always_comb begin
      if (cmd == kms_pkg::CMD_TICK) begin
         elapsed_next = (elapsed_ms < kms_pkg::ELAPSED_MAX) ?
                        elapsed_ms + kms_pkg::ELAPSED_WIDTH'(1) : elapsed_ms;
      end else if (result.hit) begin
         elapsed_next = '0;
      end else begin
         elapsed_next = elapsed_ms;
      end
   end

endmodule

@@ rtl/keypad_matrix_scanner.sv @@
`timescale 1ns / 1ps
// keypad_matrix_scanner: 4x3 telephone keypad scanner with lockout between presses.
// Depends on kms_pkg and kms_scan_core.
//
//   channel   ports                                   direction
//   req       req_valid/ready, req_cmd, req_key_levels  in
//   rsp       rsp_valid/ready, rsp_key_char, rsp_key_index out
//   csr       csr_valid/ready, csr_data (lockout_ms)    in
//
// One request per cycle while req_ready is high: the key histories, the elapsed
// counter and, on a hit, the response register all load at the edge that takes
// the request, so a response is valid in the cycle after it is taken.
// req_ready drops only while a response sits unread and rsp_ready is low.
// Synchronous active-high reset clears histories, elapsed time and the
// response valid, and loads lockout_ms with 200. csr is always ready.
module keypad_matrix_scanner #(
   parameter int HISTORY_BITS = kms_pkg::HISTORY_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [kms_pkg::KP_KEYS-1:0]         req_key_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kms_pkg::CHAR_WIDTH-1:0]      rsp_key_char,
   output logic [kms_pkg::INDEX_WIDTH-1:0]     rsp_key_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kms_pkg::ELAPSED_WIDTH-1:0]   csr_data
);

   logic [HISTORY_BITS-1:0]           hist_ff [kms_pkg::KP_KEYS];
   logic [HISTORY_BITS-1:0]           hist_in [kms_pkg::KP_KEYS];
   logic [kms_pkg::ELAPSED_WIDTH-1:0] elapsed_ff;
   logic [kms_pkg::ELAPSED_WIDTH-1:0] elapsed_in;
   logic [kms_pkg::ELAPSED_WIDTH-1:0] lockout_ff;
   logic                              rsp_valid_ff;
   logic [kms_pkg::CHAR_WIDTH-1:0]    rsp_char_ff;
   logic [kms_pkg::INDEX_WIDTH-1:0]   rsp_index_ff;
   kms_pkg::scan_result_type          result;
   logic                              req_take;

   // output slot is free, or is being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   kms_scan_core #(
      .HISTORY_BITS(HISTORY_BITS)
   ) u_core (
      .cmd          (req_cmd),
      .key_levels   (req_key_levels),
      .hist         (hist_ff),
      .elapsed_ms   (elapsed_ff),
      .lockout_ms   (lockout_ff),
      .hist_next    (hist_in),
      .elapsed_next (elapsed_in),
      .result       (result)
   );

   // key state and elapsed counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < kms_pkg::KP_KEYS; k++) begin
            hist_ff[k] <= '0;
         end
         elapsed_ff <= '0;
      end else if (req_take) begin
         hist_ff    <= hist_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // lockout register
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff <= kms_pkg::LOCKOUT_RESET;
      end else if (csr_valid && csr_ready) begin
         lockout_ff <= csr_data;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= result.hit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && result.hit) begin
         rsp_char_ff  <= kms_pkg::key_char(result.index);
         rsp_index_ff <= result.index;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_char  = rsp_char_ff;
   assign rsp_key_index = rsp_index_ff;

   // a hit restarts the lockout window
   a_hit_clears_elapsed: assert property (@(posedge clock) disable iff (reset)
      (req_take && result.hit) |=> (elapsed_ff == '0))
      else $error("elapsed not cleared after accepted key");

   // a tick never produces a response
   a_tick_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_cmd == kms_pkg::CMD_TICK) |=> !rsp_valid_ff)
      else $error("response after tick");

   // hit only when lockout has expired
   a_hit_after_lockout: assert property (@(posedge clock) disable iff (reset)
      result.hit |-> (elapsed_ff > lockout_ff))
      else $error("hit inside lockout window");

   // response index is a real key
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_index_ff <= kms_pkg::IDX_HASH))
      else $error("response key index out of range");

endmodule
